@@ rtl/core/bcfc_pkg.sv @@
package bcfc_pkg;

  // Byte counter / file length width
  localparam int LEN_W = 32;
  localparam int CFG_W = 32;

  localparam logic [15:0] FILE_FP   = 16'd3000;
  localparam logic [15:0] VER_A     = 16'd100;
  localparam logic [15:0] VER_B     = 16'd110;
  localparam logic [15:0] KIND_INFO = 16'd3010;
  localparam logic [15:0] KIND_DATA = 16'd3020;
  localparam logic [15:0] KIND_K120  = 16'd120;
  localparam logic [15:0] KIND_K130  = 16'd130;
  localparam logic [15:0] KIND_K210  = 16'd210;
  localparam logic [15:0] KIND_K1010 = 16'd1010;
  localparam logic [15:0] KIND_K1020 = 16'd1020;
  localparam logic [15:0] KIND_K2010 = 16'd2010;
  localparam logic [15:0] KIND_K2040 = 16'd2040;
  localparam logic [15:0] KIND_K6010 = 16'd6010;
  localparam logic [15:0] KIND_K6020 = 16'd6020;

  localparam logic [31:0] INFO_SIZE_A = 32'd202;
  localparam logic [31:0] INFO_SIZE_B = 32'd236;
  localparam logic [31:0] DATA_SIZE_A = 32'd10;
  localparam logic [31:0] DATA_SIZE_B = 32'd18;

  localparam logic [3:0] FILE_HDR_LEN    = 4'd8;
  localparam logic [3:0] BLK_HDR_LEN     = 4'd12;
  localparam logic [3:0] FIRST_SIZE_BYTE = 4'd8;

  typedef enum logic [4:0] {
    ST_OK            = 5'd0,
    ST_TRUNC_HDR     = 5'd1,
    ST_BAD_FP        = 5'd2,
    ST_BAD_VER       = 5'd3,
    ST_NEG_BLOCKS    = 5'd4,
    ST_TOO_MANY      = 5'd5,
    ST_TRUNC_BLK     = 5'd6,
    ST_UNSUPPORTED   = 5'd7,
    ST_NEG_CNT       = 5'd8,
    ST_NEG_SIZE      = 5'd9,
    ST_EMPTY_MISMATCH = 5'd10,
    ST_REQ_EMPTY     = 5'd11,
    ST_BEYOND_FILE   = 5'd12,
    ST_DUP_INFO      = 5'd13,
    ST_INFO_CNT      = 5'd14,
    ST_INFO_SIZE     = 5'd15,
    ST_DUP_DATA      = 5'd16,
    ST_DATA_EARLY    = 5'd17,
    ST_DATA_SIZE     = 5'd18,
    ST_TRAILING      = 5'd19,
    ST_MISSING       = 5'd20
  } status_t;

  typedef enum logic [3:0] {
    PH_FILE = 4'b0001,
    PH_BHDR = 4'b0010,
    PH_PAY  = 4'b0100,
    PH_END  = 4'b1000
  } phase_t;

  typedef struct packed {
    status_t status;
    logic    done;
  } result_t;

  function automatic logic version_ok(logic [15:0] v);
    return (v == VER_A) || (v == VER_B);
  endfunction

  function automatic logic block_ok(logic [15:0] k, logic [15:0] v);
    logic ok;
    case (k) inside
      KIND_K120, KIND_K130, KIND_K210, KIND_K1010, KIND_K1020,
      KIND_K2010, KIND_K2040, KIND_K6010, KIND_K6020: ok = (v == VER_A);
      KIND_INFO, KIND_DATA: ok = version_ok(v);
      default: ok = 1'b0;
    endcase
    return ok;
  endfunction

endpackage

@@ rtl/core/block_container_format_checker_top.sv @@
// Block container format checker: streaming structure check of a file.
// Input channel (in_valid/in_ready/in_data_byte): one file byte per request,
// in file order. Every byte yields one result request on the output channel
// (out_valid/out_ready/out_status/out_done_res): the sticky status so far,
// with out_done_res high on the last byte, where out_status is final.
// Config channel (cfg_valid/cfg_ready/cfg_file_length): total file length,
// written between files; cfg_ready is always high. Reset value is 1.
// The result for a byte is registered into the result buffer on acceptance.
// Throughput: one byte per cycle while in_ready is high; all parsing and
// block checks for a byte are combinational, and the record count x size
// product is built from one 32x8 partial product per record-size byte.
// Output stalls: a two-entry result buffer keeps in_ready high while its
// skid entry is empty; in_ready drops once both entries hold results.
// Reset (rst_n low, synchronous): parser to file-header state, buffer
// emptied, file length back to 1. After the last byte the parser restarts
// by itself for the next file.
module block_container_format_checker_top (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [7:0]                  in_data_byte,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [4:0]                  out_status,
  output logic                        out_done_res,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [bcfc_pkg::CFG_W-1:0]  cfg_file_length
);
  import bcfc_pkg::*;

  logic [CFG_W-1:0] file_length_r;
  logic             step;
  result_t          core_res, buf_res;

  assign cfg_ready = 1'b1;
  assign step      = in_valid && in_ready;

  // file length register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      file_length_r <= CFG_W'(1);
    end else if (cfg_valid) begin
      file_length_r <= cfg_file_length;
    end
  end

  // parser state and per-byte checks
  bcfc_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (step),
    .data_byte (in_data_byte),
    .flen      (LEN_W'(file_length_r)),
    .res       (core_res)
  );

  // result register with skid entry
  bcfc_skid u_skid (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (step),
    .din       (core_res),
    .ready     (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .dout      (buf_res)
  );

  assign out_status   = buf_res.status;
  assign out_done_res = buf_res.done;

endmodule

@@ rtl/core/bcfc_core.sv @@
module bcfc_core (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          step,
  input  logic [7:0]                    data_byte,
  input  logic [bcfc_pkg::LEN_W-1:0]    flen,
  output bcfc_pkg::result_t             res
);
  import bcfc_pkg::*;

  phase_t            phase_r, phase_nxt;
  logic [3:0]        fbi_r, fbi_nxt;
  logic [15:0]       kind_code_r, kind_code_nxt;
  logic [15:0]       kind_ver_r, kind_ver_nxt;
  logic [31:0]       rec_cnt_r, rec_cnt_nxt;
  logic [31:0]       rec_size_r, rec_size_nxt;
  logic [31:0]       blocks_left_r, blocks_left_nxt;
  logic [LEN_W-1:0]  byte_pos_r, byte_pos_nxt;
  logic [LEN_W-1:0]  pay_left_r, pay_left_nxt;
  logic [63:0]       prod_r, prod_nxt;
  logic              seen_info_r, seen_info_nxt;
  logic              seen_data_r, seen_data_nxt;
  status_t           sticky_r, sticky_nxt;

  logic              is_file, hdr_clr, last;
  logic [3:0]        fbi_inc;
  logic [15:0]       kc, kv;
  logic [31:0]       rc, rs, bl, bl_dec;
  logic [39:0]       pp;
  logic [63:0]       pp_sh, payload, bl12, fl8;
  logic [LEN_W-1:0]  next_pos, remain, pay_new;
  status_t           blk_st, fin_st;

  // header field assembly; a block header clears the fields on its first byte
  always_comb begin
    is_file = (phase_r == PH_FILE);
    hdr_clr = (phase_r == PH_BHDR) && (fbi_r == 4'd0);
    kc = hdr_clr ? 16'd0 : kind_code_r;
    kv = hdr_clr ? 16'd0 : kind_ver_r;
    rc = hdr_clr ? 32'd0 : rec_cnt_r;
    rs = hdr_clr ? 32'd0 : rec_size_r;
    bl = blocks_left_r;
    unique case (fbi_r)
      4'd0:  kc[7:0]   = data_byte;
      4'd1:  kc[15:8]  = data_byte;
      4'd2:  kv[7:0]   = data_byte;
      4'd3:  kv[15:8]  = data_byte;
      4'd4:  if (is_file) bl[7:0]   = data_byte; else rc[7:0]   = data_byte;
      4'd5:  if (is_file) bl[15:8]  = data_byte; else rc[15:8]  = data_byte;
      4'd6:  if (is_file) bl[23:16] = data_byte; else rc[23:16] = data_byte;
      4'd7:  if (is_file) bl[31:24] = data_byte; else rc[31:24] = data_byte;
      4'd8:  rs[7:0]   = data_byte;
      4'd9:  rs[15:8]  = data_byte;
      4'd10: rs[23:16] = data_byte;
      4'd11: rs[31:24] = data_byte;
      default: ;
    endcase
  end

  // payload = count * size, one 32x8 partial product per size byte
  always_comb begin
    pp = 40'(rec_cnt_r) * 40'(data_byte);
    case (fbi_r[1:0])
      2'd0:    pp_sh = 64'(pp);
      2'd1:    pp_sh = 64'(pp) << 8;
      2'd2:    pp_sh = 64'(pp) << 16;
      default: pp_sh = 64'(pp) << 24;
    endcase
    payload = ((fbi_r == FIRST_SIZE_BYTE) ? 64'd0 : prod_r) + pp_sh;
  end

  always_comb begin
    next_pos = byte_pos_r + LEN_W'(1);
    remain   = (flen > next_pos) ? (flen - next_pos) : '0;
    pay_new  = payload[LEN_W-1:0];
    // count > (flen-8)/12  <=>  12*count > flen-8
    bl12     = (64'(bl) << 3) + (64'(bl) << 2);
    fl8      = 64'(flen - LEN_W'(FILE_HDR_LEN));
    bl_dec   = blocks_left_r - 32'd1;
    fbi_inc  = fbi_r + 4'd1;
    last     = (next_pos == flen);
  end

  // block header checks, in priority order
  always_comb begin
    blk_st = ST_OK;
    if (!block_ok(kc, kv))                                  blk_st = ST_UNSUPPORTED;
    else if (rc[31])                                        blk_st = ST_NEG_CNT;
    else if (rs[31])                                        blk_st = ST_NEG_SIZE;
    else if ((rc == 32'd0) != (rs == 32'd0))                blk_st = ST_EMPTY_MISMATCH;
    else if ((rc == 32'd0) && ((kc == KIND_INFO) || (kc == KIND_DATA)))
                                                            blk_st = ST_REQ_EMPTY;
    else if (payload > 64'(remain))                         blk_st = ST_BEYOND_FILE;
    else if (kc == KIND_INFO) begin
      if (seen_info_r)                                      blk_st = ST_DUP_INFO;
      else if (rc != 32'd1)                                 blk_st = ST_INFO_CNT;
      else if (rs != ((kv == VER_A) ? INFO_SIZE_A : INFO_SIZE_B))
                                                            blk_st = ST_INFO_SIZE;
    end else if (kc == KIND_DATA) begin
      if (seen_data_r)                                      blk_st = ST_DUP_DATA;
      else if (!seen_info_r)                                blk_st = ST_DATA_EARLY;
      else if (rs != ((kv == VER_A) ? DATA_SIZE_A : DATA_SIZE_B))
                                                            blk_st = ST_DATA_SIZE;
    end
  end

  always_comb begin
    phase_nxt       = phase_r;
    fbi_nxt         = fbi_r;
    kind_code_nxt   = kind_code_r;
    kind_ver_nxt    = kind_ver_r;
    rec_cnt_nxt     = rec_cnt_r;
    rec_size_nxt    = rec_size_r;
    blocks_left_nxt = blocks_left_r;
    pay_left_nxt    = pay_left_r;
    prod_nxt        = prod_r;
    seen_info_nxt   = seen_info_r;
    seen_data_nxt   = seen_data_r;
    sticky_nxt      = sticky_r;
    byte_pos_nxt    = next_pos;
    if (sticky_r == ST_OK) begin
      unique case (phase_r)
        PH_FILE: begin
          if (flen < LEN_W'(FILE_HDR_LEN)) begin
            sticky_nxt = ST_TRUNC_HDR;
          end else begin
            kind_code_nxt   = kc;
            kind_ver_nxt    = kv;
            blocks_left_nxt = bl;
            fbi_nxt         = fbi_inc;
            if (fbi_inc == FILE_HDR_LEN) begin
              fbi_nxt = 4'd0;
              if (kc != FILE_FP)       sticky_nxt = ST_BAD_FP;
              else if (!version_ok(kv)) sticky_nxt = ST_BAD_VER;
              else if (bl[31])          sticky_nxt = ST_NEG_BLOCKS;
              else if (bl12 > fl8)      sticky_nxt = ST_TOO_MANY;
              else phase_nxt = (bl != 32'd0) ? PH_BHDR : PH_END;
            end
          end
        end
        PH_BHDR: begin
          kind_code_nxt = kc;
          kind_ver_nxt  = kv;
          rec_cnt_nxt   = rc;
          rec_size_nxt  = rs;
          prod_nxt      = payload;
          fbi_nxt       = fbi_inc;
          if (fbi_inc == BLK_HDR_LEN) begin
            fbi_nxt    = 4'd0;
            sticky_nxt = blk_st;
            if (blk_st == ST_OK) begin
              seen_info_nxt   = seen_info_r | (kc == KIND_INFO);
              seen_data_nxt   = seen_data_r | (kc == KIND_DATA);
              pay_left_nxt    = pay_new;
              blocks_left_nxt = bl_dec;
              if (pay_new != '0)         phase_nxt = PH_PAY;
              else if (bl_dec != 32'd0)  phase_nxt = PH_BHDR;
              else                       phase_nxt = PH_END;
            end
          end
        end
        PH_PAY: begin
          pay_left_nxt = pay_left_r - LEN_W'(1);
          if (pay_left_nxt == '0)
            phase_nxt = (blocks_left_r != 32'd0) ? PH_BHDR : PH_END;
        end
        PH_END: sticky_nxt = ST_TRAILING;
        default: ;
      endcase
    end
  end

  // end-of-file checks
  always_comb begin
    fin_st = sticky_nxt;
    if (last && (sticky_nxt == ST_OK)) begin
      unique case (phase_nxt)
        PH_FILE: fin_st = ST_TRUNC_HDR;
        PH_BHDR: fin_st = ST_TRUNC_BLK;
        PH_PAY:  fin_st = ST_BEYOND_FILE;
        PH_END:  if (!(seen_info_nxt && seen_data_nxt)) fin_st = ST_MISSING;
        default: ;
      endcase
    end
    res.status = fin_st;
    res.done   = last;
  end

  always_ff @(posedge clk) begin
    if (!rst_n || (step && last)) begin
      phase_r       <= PH_FILE;
      fbi_r         <= 4'd0;
      kind_code_r   <= 16'd0;
      kind_ver_r    <= 16'd0;
      rec_cnt_r     <= 32'd0;
      rec_size_r    <= 32'd0;
      blocks_left_r <= 32'd0;
      byte_pos_r    <= '0;
      pay_left_r    <= '0;
      seen_info_r   <= 1'b0;
      seen_data_r   <= 1'b0;
      sticky_r      <= ST_OK;
    end else if (step) begin
      phase_r       <= phase_nxt;
      fbi_r         <= fbi_nxt;
      kind_code_r   <= kind_code_nxt;
      kind_ver_r    <= kind_ver_nxt;
      rec_cnt_r     <= rec_cnt_nxt;
      rec_size_r    <= rec_size_nxt;
      blocks_left_r <= blocks_left_nxt;
      byte_pos_r    <= byte_pos_nxt;
      pay_left_r    <= pay_left_nxt;
      seen_info_r   <= seen_info_nxt;
      seen_data_r   <= seen_data_nxt;
      sticky_r      <= sticky_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      prod_r <= prod_nxt;
    end
  end

endmodule

@@ rtl/core/bcfc_skid.sv @@
module bcfc_skid (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  bcfc_pkg::result_t  din,
  output logic               ready,
  output logic               out_valid,
  input  logic               out_ready,
  output bcfc_pkg::result_t  dout
);
  import bcfc_pkg::*;

  result_t head_r, skid_r;
  logic    head_valid_r, skid_valid_r;
  logic    pop;

  assign pop       = head_valid_r && out_ready;
  assign ready     = !skid_valid_r;
  assign out_valid = head_valid_r;
  assign dout      = head_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_valid_r <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (skid_valid_r) begin
      if (pop) begin
        skid_valid_r <= 1'b0;
      end
    end else if (push) begin
      if (head_valid_r && !pop) begin
        skid_valid_r <= 1'b1;
      end
      head_valid_r <= 1'b1;
    end else if (pop) begin
      head_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid_r) begin
      if (pop) begin
        head_r <= skid_r;
      end
    end else if (push) begin
      if (head_valid_r && !pop) begin
        skid_r <= din;
      end else begin
        head_r <= din;
      end
    end
  end

endmodule

@@ rtl/core/bcfc_checker.sv @@
module bcfc_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [4:0] out_status,
  input logic       out_done_res,
  input logic       cfg_ready
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status) && $stable(out_done_res))
    else $error("result changed while stalled");

  // status code in range
  a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_status <= 5'd20)
    else $error("status out of range");

  // input only backs up when results are waiting
  a_ready_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid)
    else $error("in_ready low with empty output");

  // full buffer drains one entry per taken result, freeing the input
  a_ready_recover: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready && out_ready |=> in_ready)
    else $error("in_ready not restored after a result was taken");

  // config port never stalls
  a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> cfg_ready)
    else $error("cfg_ready low");

endmodule

bind block_container_format_checker_top bcfc_checker u_bcfc_checker (.*);

@@ tb/tb_block_container_format_checker_top.sv @@
module tb_block_container_format_checker_top;
  timeunit 1ns;
  timeprecision 1ps;

  import bcfc_pkg::*;

  // ---------------------------------------------------------------------------
  // Clock, reset, DUT ports. Every DUT input starts at a known value.
  // ---------------------------------------------------------------------------
  logic        clk             = 1'b0;
  logic        rst_n           = 1'b0;
  logic        in_valid        = 1'b0;
  logic        in_ready;
  logic [7:0]  in_data_byte    = 8'd0;
  logic        out_valid;
  logic        out_ready       = 1'b0;
  logic [4:0]  out_status;
  logic        out_done_res;
  logic        cfg_valid       = 1'b0;
  logic        cfg_ready;
  logic [CFG_W-1:0] cfg_file_length = '0;

  always #4 clk = ~clk;

  block_container_format_checker_top u_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_data_byte   (in_data_byte),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_status     (out_status),
    .out_done_res   (out_done_res),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_file_length(cfg_file_length)
  );

  // ---------------------------------------------------------------------------
  // Shared bookkeeping between stimulus, driver and monitor.
  // ---------------------------------------------------------------------------
  logic [7:0] pend_q[$];        // bytes waiting to be offered
  result_t    verdicts_due[$];  // predicted results, oldest first
  int         n_queued  = 0;    // bytes handed to the driver
  int         n_taken   = 0;    // byte requests accepted by the DUT
  int         n_err     = 0;
  logic       hold_req  = 1'b0; // ask the receiver for one long hold-off

  // ---------------------------------------------------------------------------
  // Parser mirror: own copy of the checker state and of file_length.
  // ---------------------------------------------------------------------------
  logic [31:0] flen_q       = 32'd1;   // register value after reset
  phase_t      p_phase      = PH_FILE;
  logic [3:0]  p_idx        = '0;
  logic [15:0] p_kind       = '0;
  logic [15:0] p_ver        = '0;
  logic [31:0] p_cnt        = '0;
  logic [31:0] p_size       = '0;
  logic [31:0] p_blocks     = '0;
  logic [31:0] p_pos        = '0;
  logic [31:0] p_skip       = '0;
  logic        p_info       = 1'b0;
  logic        p_data       = 1'b0;
  status_t     p_status     = ST_OK;

  task automatic parser_clear();
    p_phase  = PH_FILE;
    p_idx    = '0;
    p_kind   = '0;
    p_ver    = '0;
    p_cnt    = '0;
    p_size   = '0;
    p_blocks = '0;
    p_pos    = '0;
    p_skip   = '0;
    p_info   = 1'b0;
    p_data   = 1'b0;
    p_status = ST_OK;
  endtask

  function automatic logic kind_known(logic [15:0] k, logic [15:0] v);
    case (k)
      KIND_K120, KIND_K130, KIND_K210, KIND_K1010, KIND_K1020,
      KIND_K2010, KIND_K2040, KIND_K6010, KIND_K6020: return v == VER_A;
      KIND_INFO, KIND_DATA: return (v == VER_A) || (v == VER_B);
      default: return 1'b0;
    endcase
  endfunction

  // Next block header or end of the block list.
  function automatic void block_finished();
    p_phase = (p_blocks != 0) ? PH_BHDR : PH_END;
  endfunction

  // Checks of a complete block header, in priority order.
  function automatic status_t judge_block(logic [31:0] nxt);
    logic [63:0] body;
    logic [63:0] room;
    logic        cnt_zero;
    logic        size_zero;
    cnt_zero  = (p_cnt == 0);
    size_zero = (p_size == 0);
    if (!kind_known(p_kind, p_ver)) return ST_UNSUPPORTED;
    if (p_cnt[31]) return ST_NEG_CNT;
    if (p_size[31]) return ST_NEG_SIZE;
    if (cnt_zero != size_zero) return ST_EMPTY_MISMATCH;
    if (cnt_zero && (p_kind == KIND_INFO || p_kind == KIND_DATA)) return ST_REQ_EMPTY;
    body = {32'd0, p_cnt} * {32'd0, p_size};
    room = (flen_q > nxt) ? {32'd0, flen_q - nxt} : 64'd0;
    if (body > room) return ST_BEYOND_FILE;
    if (p_kind == KIND_INFO) begin
      if (p_info) return ST_DUP_INFO;
      if (p_cnt != 1) return ST_INFO_CNT;
      if (p_size != ((p_ver == VER_A) ? INFO_SIZE_A : INFO_SIZE_B)) return ST_INFO_SIZE;
      p_info = 1'b1;
    end else if (p_kind == KIND_DATA) begin
      if (p_data) return ST_DUP_DATA;
      if (!p_info) return ST_DATA_EARLY;
      if (p_size != ((p_ver == VER_A) ? DATA_SIZE_A : DATA_SIZE_B)) return ST_DATA_SIZE;
      p_data = 1'b1;
    end
    p_skip   = body[31:0];
    p_blocks = p_blocks - 1;
    if (p_skip == 0) block_finished();
    else p_phase = PH_PAY;
    return ST_OK;
  endfunction

  // One byte through the mirror; returns the result it must produce.
  task automatic parse_byte(input logic [7:0] b, output result_t r);
    logic [31:0] nxt;
    logic        is_last;
    int          k;
    nxt     = p_pos + 1;
    is_last = (nxt == flen_q);
    k       = p_idx;
    if (p_status == ST_OK) begin
      case (p_phase)
        PH_FILE: begin
          if (flen_q < 8) begin
            p_status = ST_TRUNC_HDR;
          end else begin
            if (k < 2) p_kind[8*k +: 8] = b;
            else if (k < 4) p_ver[8*(k-2) +: 8] = b;
            else p_blocks[8*(k-4) +: 8] = b;
            k++;
            p_idx = 4'(k);
            if (k == 8) begin
              p_idx = '0;
              if (p_kind != FILE_FP) p_status = ST_BAD_FP;
              else if (p_ver != VER_A && p_ver != VER_B) p_status = ST_BAD_VER;
              else if (p_blocks[31]) p_status = ST_NEG_BLOCKS;
              else if (p_blocks > (flen_q - 8) / 12) p_status = ST_TOO_MANY;
              else block_finished();
            end
          end
        end
        PH_BHDR: begin
          if (k == 0) begin
            p_kind = '0;
            p_ver  = '0;
            p_cnt  = '0;
            p_size = '0;
          end
          if (k < 2) p_kind[8*k +: 8] = b;
          else if (k < 4) p_ver[8*(k-2) +: 8] = b;
          else if (k < 8) p_cnt[8*(k-4) +: 8] = b;
          else p_size[8*(k-8) +: 8] = b;
          k++;
          p_idx = 4'(k);
          if (k == 12) begin
            p_idx    = '0;
            p_status = judge_block(nxt);
          end
        end
        PH_PAY: begin
          p_skip = p_skip - 1;
          if (p_skip == 0) block_finished();
        end
        default: p_status = ST_TRAILING;
      endcase
    end
    p_pos = nxt;
    // end-of-file checks only when nothing was flagged yet
    if (is_last && p_status == ST_OK) begin
      case (p_phase)
        PH_FILE: p_status = ST_TRUNC_HDR;
        PH_BHDR: p_status = ST_TRUNC_BLK;
        PH_PAY:  p_status = ST_BEYOND_FILE;
        default: if (!p_info || !p_data) p_status = ST_MISSING;
      endcase
    end
    r.status = p_status;
    r.done   = is_last;
    if (is_last) parser_clear();
  endtask

  // ---------------------------------------------------------------------------
  // Driver: offers bytes from pend_q in bursts with gaps; predicts on accept.
  // ---------------------------------------------------------------------------
  int burst_left = 0;
  int gap_left   = 0;

  always @(posedge clk) begin : tx_side
    result_t r;
    if (rst_n) begin
      if (in_valid && in_ready) begin
        parse_byte(in_data_byte, r);
        verdicts_due.push_back(r);
        n_taken++;
      end
      // slot is free unless a request is still waiting for ready
      if (!in_valid || in_ready) begin
        if (gap_left != 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (pend_q.size() != 0) begin
          in_valid     <= 1'b1;
          in_data_byte <= pend_q.pop_front();
          if (burst_left > 1) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 48);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: checks each result request, drives out_ready on its own pattern.
  // ---------------------------------------------------------------------------
  typedef enum int {RX_FREE, RX_COIN, RX_SPARSE, RX_MOSTLY} rx_mode_t;

  rx_mode_t    rx_mode   = RX_FREE;
  logic [31:0] rx_tick   = '0;
  int          hold_left = 0;

  always @(posedge clk) begin : rx_side
    result_t want;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (verdicts_due.size() == 0) begin
          $display("%0t: unexpected result, status %0d done %0b",
                   $time, out_status, out_done_res);
          n_err++;
        end else begin
          want = verdicts_due.pop_front();
          if (out_status !== want.status) begin
            $display("%0t: status mismatch: expected %0d, actual %0d",
                     $time, want.status, out_status);
            n_err++;
          end
          if (out_done_res !== want.done) begin
            $display("%0t: done_res mismatch: expected %0b, actual %0b",
                     $time, want.done, out_done_res);
            n_err++;
          end
        end
      end
      rx_tick++;
      if (rx_tick[5:0] == 0) rx_mode = rx_mode_t'($urandom_range(0, 3));
      if (hold_req && hold_left == 0) begin
        hold_left = 400;
        hold_req  = 1'b0;
      end
      if (hold_left != 0) begin
        // long hold-off: buffer fills, in_ready must drop
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        case (rx_mode)
          RX_FREE:   out_ready <= 1'b1;
          RX_COIN:   out_ready <= ($urandom_range(0, 1) == 1);
          RX_SPARSE: out_ready <= (rx_tick[1:0] == 2'd0);
          default:   out_ready <= ($urandom_range(0, 6) != 0);
        endcase
      end
    end
  end

  // ---------------------------------------------------------------------------
  // File image builder.
  // ---------------------------------------------------------------------------
  typedef struct {
    logic [15:0] kind;
    logic [15:0] ver;
    logic [31:0] cnt;
    logic [31:0] size;
  } blk_t;

  logic [7:0] img[$];

  function automatic logic [15:0] plain_kind(int i);
    case (i)
      0: return KIND_K120;
      1: return KIND_K130;
      2: return KIND_K210;
      3: return KIND_K1010;
      4: return KIND_K1020;
      5: return KIND_K2010;
      6: return KIND_K2040;
      7: return KIND_K6010;
      default: return KIND_K6020;
    endcase
  endfunction

  task automatic put_le(input logic [31:0] w);
    for (int i = 0; i < 4; i++) img.push_back(w[8*i +: 8]);
  endtask

  task automatic put_file_hdr(input logic [15:0] fp, input logic [15:0] ver,
                              input logic [31:0] nblk);
    put_le({ver, fp});
    put_le(nblk);
  endtask

  // Block header plus payload; payload is capped for oversized blocks,
  // which are rejected at the header anyway.
  task automatic put_blk(input blk_t b);
    logic [63:0] body;
    put_le({b.ver, b.kind});
    put_le(b.cnt);
    put_le(b.size);
    if (!b.cnt[31] && !b.size[31]) begin
      body = {32'd0, b.cnt} * {32'd0, b.size};
      if (body > 64'd600) body = 64'd600;
      repeat (int'(body)) img.push_back(8'($urandom));
    end
  endtask

  function automatic blk_t mk_blk(logic [15:0] kind, logic [15:0] ver,
                                  logic [31:0] cnt, logic [31:0] size);
    blk_t b;
    b.kind = kind;
    b.ver  = ver;
    b.cnt  = cnt;
    b.size = size;
    return b;
  endfunction

  // ---------------------------------------------------------------------------
  // Phase control: config writes only once every result has come back.
  // ---------------------------------------------------------------------------
  task automatic wait_idle();
    do @(posedge clk); while (!(n_taken == n_queued && verdicts_due.size() == 0));
    repeat (2) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [31:0] v);
    wait_idle();
    cfg_valid       <= 1'b1;
    cfg_file_length <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    flen_q = v;
  endtask

  // Hand the first n bytes of the image to the driver.
  task automatic flush_n(input int n);
    repeat (n) begin
      pend_q.push_back(img.pop_front());
      n_queued++;
    end
  endtask

  // Well-formed v110 file using every plain kind, one of them empty.
  task automatic build_all_kinds();
    put_file_hdr(FILE_FP, VER_B, 32'd11);
    put_blk(mk_blk(KIND_K120, VER_A, 32'd0, 32'd0));
    put_blk(mk_blk(KIND_INFO, VER_A, 32'd1, INFO_SIZE_A));
    for (int i = 1; i < 9; i++)
      put_blk(mk_blk(plain_kind(i), VER_A, 32'd1, 32'd1));
    put_blk(mk_blk(KIND_DATA, VER_B, 32'd1, DATA_SIZE_B));
  endtask

  // Random bytes, often behind a valid file header.
  task automatic gen_noise_file();
    int n;
    if ($urandom_range(0, 1)) put_file_hdr(FILE_FP, VER_A, 32'($urandom_range(0, 3)));
    n = $urandom_range(1, 24);
    repeat (n) img.push_back(8'($urandom));
    cfg_write(img.size());
    flush_n(img.size());
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus sequence.
  // ---------------------------------------------------------------------------
  initial begin : stim
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // length from reset (1): single byte, short header
    img.push_back(8'hFF);
    flush_n(1);

    // short file of 7 bytes
    cfg_write(32'd7);
    for (int i = 0; i < 7; i++) img.push_back((i % 2) ? 8'h00 : 8'hFF);
    flush_n(7);

    // header-only files back to back: no blocks, bad fingerprint,
    // bad version, negative count, count too large for the length
    cfg_write(32'd8);
    put_file_hdr(FILE_FP, VER_B, 32'd0);
    put_file_hdr(16'hFFFF, VER_A, 32'd0);
    put_file_hdr(FILE_FP, 16'd0, 32'd0);
    put_file_hdr(FILE_FP, VER_A, 32'hFFFF_FFFF);
    put_file_hdr(FILE_FP, VER_A, 32'd1);
    flush_n(img.size());

    // every block kind, accepted; receiver holds off meanwhile
    build_all_kinds();
    cfg_write(img.size());
    hold_req = 1'b1;
    flush_n(img.size());

    // bytes after an empty block list
    cfg_write(32'd11);
    put_file_hdr(FILE_FP, VER_A, 32'd0);
    repeat (3) img.push_back(8'($urandom));
    flush_n(img.size());

    // stream ends in the middle of a block header
    put_file_hdr(FILE_FP, VER_A, 32'd2);
    put_blk(mk_blk(KIND_K120, VER_A, 32'd1, 32'd8));
    repeat (5) img.push_back(8'h5A);
    cfg_write(img.size());
    flush_n(img.size());
    // stream ends where the next block header is due
    put_file_hdr(FILE_FP, VER_A, 32'd2);
    put_blk(mk_blk(KIND_K2040, VER_A, 32'd1, 32'd16));
    cfg_write(img.size());
    flush_n(img.size());

    // length rewritten mid-file: max, then below the bytes taken,
    // then a value that ends the file inside the payload
    cfg_write(32'hFFFF_FFFF);
    put_file_hdr(FILE_FP, VER_A, 32'd2);
    put_blk(mk_blk(KIND_K120, VER_A, 32'd1, 32'd40));
    flush_n(25);
    cfg_write(32'd20);
    flush_n(5);
    cfg_write(32'd35);
    flush_n(5);
    img.delete();

    // random bytes
    gen_noise_file();
    img.delete();

    wait_idle();
    repeat (8) @(posedge clk);
    if (n_err == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // Watchdog.
  initial begin : watchdog
    #10ms;
    $display("status: fail");
    $finish;
  end

endmodule

@@ files.f @@
rtl/core/bcfc_pkg.sv
rtl/core/bcfc_core.sv
rtl/core/bcfc_skid.sv
rtl/core/block_container_format_checker_top.sv
rtl/core/bcfc_checker.sv
tb/tb_block_container_format_checker_top.sv
